[src/ckct_pkg.sv]
// ============================================================================
// ckct_pkg
// Shared types and constants for the key candidate tester.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
package ckct_pkg;
   localparam logic [31:0] FEI_CONST_A = 32'h5B2C004A;
   localparam logic [31:0] FEI_CONST_B = 32'h803425C3;
   localparam int FEI_ROUNDS  = 6;
   localparam int SCHED_WORDS = 26;
   localparam int SOFT_ITERS  = 12;

   localparam logic [1:0] REG_C0 = 2'd0;
   localparam logic [1:0] REG_P0 = 2'd1;
   localparam logic [1:0] REG_C1 = 2'd2;
   localparam logic [1:0] REG_P1 = 2'd3;

   // rotation amounts per feistel round
   function automatic logic [4:0] rot_a(input int j);
      logic [4:0] r;
      unique case (j)
         0: r = 5'd25;
         1: r = 5'd20;
         2: r = 5'd15;
         3: r = 5'd10;
         4: r = 5'd5;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] rot_b(input int j);
      logic [4:0] r;
      unique case (j)
         0: r = 5'd10;
         1: r = 5'd8;
         2: r = 5'd6;
         3: r = 5'd4;
         4: r = 5'd2;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] d;
      d = {v, v} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] d;
      d = {v, v} >> n;
      return d[31:0];
   endfunction

   // per-item record passed from front to back
   typedef struct packed {
      logic        pass1;
      logic [31:0] dw;
      logic [31:0] guess;
   } front_item_type;
endpackage
`default_nettype wire

[src/cipher_key_candidate_tester.sv]
// ============================================================================
// cipher_key_candidate_tester
// Key guess screening and verification against two known block pairs.
// ============================================================================
// Usage: write the four 64-bit block registers through the csr_ port while
// idle, then stream guesses on req_ (valid/stall). Each guess gives one beat
// on rsp_ carrying first_pass, verified and derived_word, in order.
// Throughput: one guess per clock while req_stall is low. Guesses pass
// through the feistel screening pipe, the queue, then the schedule
// and decrypt pipe (one stage per schedule word and per half-round).
// While rsp_valid and rsp_stall are both high the back pipe holds; the
// queue keeps absorbing front beats until full, then req_stall rises and
// the front holds. Reset is synchronous and empties both pipes and the
// queue; the block registers clear to zero.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module cipher_key_candidate_tester
   import ckct_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [31:0]    req_guess,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic                rsp_first_pass,
   output logic                rsp_verified,
   output logic [31:0]         rsp_derived_word,
   input  wire logic           csr_write,
   input  wire logic [1:0]     csr_index,
   input  wire logic [63:0]    csr_data
);
   logic [63:0] c0_ff, p0_ff, c1_ff, p1_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= '0; p0_ff <= '0; c1_ff <= '0; p1_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_C0: c0_ff <= csr_data;
            REG_P0: p0_ff <= csr_data;
            REG_C1: c1_ff <= csr_data;
            REG_P1: p1_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic           f_valid, f_adv, q_full, q_ne, q_wr, q_rd, b_adv;
   front_item_type f_item, q_item;

   // front moves unless its last stage holds a beat the queue cannot take
   assign f_adv     = !(f_valid && q_full);
   assign q_wr      = f_valid && !q_full;
   assign req_stall = !f_adv;
   assign b_adv     = !(rsp_valid && rsp_stall);
   assign q_rd      = q_ne && b_adv;

   ckct_front u_front (
      .clock, .reset,
      .in_valid (req_valid), .in_guess (req_guess),
      .c0 (c0_ff), .p0 (p0_ff),
      .out_valid (f_valid), .out_item (f_item), .advance (f_adv)
   );

   ckct_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .wr_en (q_wr), .wr_item (f_item), .full (q_full),
      .not_empty (q_ne), .rd_item (q_item), .rd_en (q_rd)
   );

   ckct_back u_back (
      .clock, .reset,
      .in_valid (q_rd), .in_item (q_item),
      .c0 (c0_ff), .c1 (c1_ff), .p1 (p1_ff), .advance (b_adv),
      .out_valid (rsp_valid), .out_pass1 (rsp_first_pass),
      .out_ok (rsp_verified), .out_dw (rsp_derived_word)
   );
endmodule
`default_nettype wire

[src/ckct_front.sv]
// ============================================================================
// ckct_front
// Feistel screening pipeline: one register stage per feistel round.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module ckct_front
   import ckct_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire logic [31:0]    in_guess,
   input  wire logic [63:0]    c0,
   input  wire logic [63:0]    p0,
   output logic                out_valid,
   output front_item_type      out_item,
   input  wire logic           advance
);
   localparam int NST = 2 * FEI_ROUNDS;

   logic [NST:0]        vld_ff;
   logic [31:0]         a_ff [NST+1];
   logic [31:0]         b_ff [NST+1];
   logic [31:0]         g_ff [NST+1];
   logic [NST:0]        vld_in;
   logic [31:0]         a_in [NST+1];
   logic [31:0]         b_in [NST+1];
   logic [31:0]         g_in [NST+1];

   // stage next values, whole pipe moves on advance
   always_comb begin
      vld_in[0] = in_valid;
      a_in[0]   = c0[31:0];
      b_in[0]   = c0[63:32];
      g_in[0]   = in_guess;
      for (int s = 1; s <= NST; s++) begin
         vld_in[s] = vld_ff[s-1];
         g_in[s]   = g_ff[s-1];
         b_in[s]   = a_ff[s-1];
         if (s <= FEI_ROUNDS) begin
            a_in[s] = b_ff[s-1] ^ rotl(a_ff[s-1] ^ FEI_CONST_A, rot_a(s-1));
         end else begin
            a_in[s] = b_ff[s-1] ^ rotl(a_ff[s-1] ^ FEI_CONST_B, rot_b(s-1-FEI_ROUNDS));
         end
         // swap between the two feistels; key injection is in the register stage
         if (s == FEI_ROUNDS + 1) begin
            a_in[s] = b_ff[s-1] ^ rotl(a_ff[s-1] ^ FEI_CONST_B, rot_b(0));
            b_in[s] = a_ff[s-1];
         end
      end
   end

   // stage between feistels: a = b1 ^ g, b = a1 handled at stage FEI_ROUNDS+1 input
   logic [31:0] a_mid, b_mid;
   always_comb begin
      a_mid = b_ff[FEI_ROUNDS] ^ g_ff[FEI_ROUNDS];
      b_mid = a_ff[FEI_ROUNDS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= NST; s++) begin
            g_ff[s] <= g_in[s];
            if (s == FEI_ROUNDS + 1) begin
               a_ff[s] <= b_mid ^ rotl(a_mid ^ FEI_CONST_B, rot_b(0));
               b_ff[s] <= a_mid;
            end else begin
               a_ff[s] <= a_in[s];
               b_ff[s] <= b_in[s];
            end
         end
      end
   end

   assign out_valid      = vld_ff[NST];
   assign out_item.pass1 = (a_ff[NST] == p0[63:32]);
   assign out_item.dw    = p0[31:0] ^ b_ff[NST];
   assign out_item.guess = g_ff[NST];
endmodule
`default_nettype wire

[src/ckct_queue.sv]
// ============================================================================
// ckct_queue
// Small fifo decoupling the screening front from the verify back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module ckct_queue
   import ckct_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire front_item_type wr_item,
   output logic                full,
   output logic                not_empty,
   output front_item_type      rd_item,
   input  wire logic           rd_en
);
   localparam int AW = $clog2(DEPTH);
   front_item_type     mem_ff [DEPTH];
   logic [AW-1:0]      wp_ff, rp_ff;
   logic [AW:0]        cnt_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (rd_en) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_item;
   end

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign rd_item   = mem_ff[rp_ff];
endmodule
`default_nettype wire

[src/ckct_back.sv]
// ============================================================================
// ckct_back
// Key schedule expansion and block one decryption, one stage per step.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module ckct_back
   import ckct_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire front_item_type in_item,
   input  wire logic [63:0]    c0,
   input  wire logic [63:0]    c1,
   input  wire logic [63:0]    p1,
   input  wire logic           advance,
   output logic                out_valid,
   output logic                out_pass1,
   output logic                out_ok,
   output logic [31:0]         out_dw
);
   localparam int KS = SCHED_WORDS - 1;   // expansion stages
   localparam int MS = 2 * SOFT_ITERS;    // half-round stages
   localparam int NST = KS + MS;

   logic [NST:0]       vld_ff;
   logic [NST:0]       p_ff;
   logic [31:0]        d_ff   [NST+1];
   logic [31:0]        g_ff   [NST+1];
   logic [31:0]        run_ff [NST+1];
   logic [31:0]        last_ff[NST+1];
   logic [31:0]        ks_ff  [NST+1][SCHED_WORDS];
   logic [31:0]        a_ff   [NST+1];
   logic [31:0]        b_ff   [NST+1];

   logic [NST:0]       p_in;
   logic [31:0]        d_in   [NST+1];
   logic [31:0]        g_in   [NST+1];
   logic [31:0]        run_in [NST+1];
   logic [31:0]        last_in[NST+1];
   logic [31:0]        ks_in  [NST+1][SCHED_WORDS];
   logic [31:0]        a_in   [NST+1];
   logic [31:0]        b_in   [NST+1];

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-1:0], in_valid};
      end
   end

   // stage 0 load, then one expansion or half-round step per stage
   always_comb begin
      int h, j;
      p_in[0]    = in_item.pass1;
      d_in[0]    = in_item.dw;
      g_in[0]    = in_item.guess;
      run_in[0]  = in_item.dw;
      last_in[0] = in_item.dw;
      for (int k = 0; k < SCHED_WORDS; k++) ks_in[0][k] = in_item.dw;
      a_in[0]    = c1[31:0];
      b_in[0]    = c1[63:32];
      for (int s = 1; s <= NST; s++) begin
         p_in[s]    = p_ff[s-1];
         d_in[s]    = d_ff[s-1];
         g_in[s]    = g_ff[s-1];
         ks_in[s]   = ks_ff[s-1];
         run_in[s]  = run_ff[s-1];
         last_in[s] = last_ff[s-1];
         a_in[s]    = a_ff[s-1];
         b_in[s]    = b_ff[s-1];
         if (s <= KS) begin
            // ks[s] = ks[s-1]+g, run rotated by ks[s-1], folded into ks[1]
            ks_in[s][s] = last_ff[s-1] + g_ff[s-1];
            run_in[s]   = rotr(run_ff[s-1], last_ff[s-1][4:0]);
            ks_in[s][1] = ks_in[s][1] ^ run_in[s];
            last_in[s]  = ks_in[s][s];
         end else begin
            // half-round pairs, j counts down from SOFT_ITERS
            h = s - KS - 1;
            j = SOFT_ITERS - (h >> 1);
            if ((h & 1) == 0) begin
               a_in[s] = rotr(a_ff[s-1] - ks_ff[s-1][2*j+1], b_ff[s-1][11:7])
                         ^ b_ff[s-1];
            end else begin
               b_in[s] = rotr(b_ff[s-1] + ks_ff[s-1][2*j], a_ff[s-1][8:4])
                         ^ a_ff[s-1];
            end
         end
      end
   end

   // whole pipe moves on advance
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff    <= p_in;
         d_ff    <= d_in;
         g_ff    <= g_in;
         run_ff  <= run_in;
         last_ff <= last_in;
         ks_ff   <= ks_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
      end
   end

   assign out_valid = vld_ff[NST];
   assign out_pass1 = p_ff[NST];
   assign out_dw    = d_ff[NST];
   assign out_ok    = p_ff[NST] && (a_ff[NST] == (p1[31:0] ^ c0[31:0]))
                      && (b_ff[NST] == (p1[63:32] ^ c0[63:32]));
endmodule
`default_nettype wire
